// ===== src/mbrf_pkg.sv =====
// Shared constants, types and helpers for the mirrored byte ring FIFO.
// No dependencies; used by every module of the block.
`default_nettype none

package mbrf_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CAP_W       = 11;
  localparam int LEN_W       = 7;
  localparam int MAX_BLOCK   = 64;
  localparam int ALIGN_UNIT  = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CAP_W-1:0] CAP_TOP   = CAP_W'(STORE_DEPTH & ~(ALIGN_UNIT - 1));
  localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(ALIGN_UNIT);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  // command codes on the input port
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_FORCE = 2'd1;
  localparam logic [1:0] CMD_POP   = 2'd2;
  localparam logic [1:0] CMD_BLOCK = 2'd3;

  // classified operations handed to the back end
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_FORCE  = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_REFUSE = 2'd3;

  // fifo_status codes
  localparam logic [1:0] STATUS_EMPTY   = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_PARTIAL = 2'd2;

  // register index of capacity
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] len;
  } queue_entry_t;

  typedef struct packed {
    logic              wrap;
    logic [ADDR_W-1:0] pos;
  } ptr_t;

  // step an index by one within the capacity in use, toggling its mirror bit on wrap
  function automatic ptr_t advance(input ptr_t p, input logic [CAP_W-1:0] cap);
    ptr_t r;
    r = p;
    if ((CAP_W'(p.pos) + CAP_W'(1)) >= cap) begin
      r.pos  = '0;
      r.wrap = ~p.wrap;
    end else begin
      r.pos = p.pos + ADDR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [1:0] status_of(input logic [CAP_W-1:0] fill,
                                           input logic [CAP_W-1:0] cap);
    logic [1:0] s;
    if (fill == '0) begin
      s = STATUS_EMPTY;
    end else if (fill == cap) begin
      s = STATUS_FULL;
    end else begin
      s = STATUS_PARTIAL;
    end
    return s;
  endfunction

  // align down to 4 and clamp into the legal range
  function automatic logic [CAP_W-1:0] cap_in_use(input logic [CAP_W-1:0] raw);
    logic [CAP_W-1:0] c;
    c = {raw[CAP_W-1:2], 2'b00};
    if (c < CAP_MIN) begin
      c = CAP_MIN;
    end else if (c > CAP_TOP) begin
      c = CAP_TOP;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/mbrf_front.sv =====
// Front end: takes commands, classifies them and queues them for the back end.
// Depends on mbrf_pkg.
`default_nettype none

module mbrf_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   command,
  input  wire logic [7:0]                   data_byte,
  input  wire logic [mbrf_pkg::LEN_W-1:0]   block_length,
  output logic                              q_valid,
  output mbrf_pkg::queue_entry_t            q_entry,
  input  wire logic                         q_take
);

  mbrf_pkg::queue_entry_t                slots [mbrf_pkg::QUEUE_DEPTH];
  logic [mbrf_pkg::QPTR_W-1:0]           wr_ptr;
  logic [mbrf_pkg::QPTR_W-1:0]           rd_ptr;
  logic [mbrf_pkg::QCNT_W-1:0]           cnt;
  mbrf_pkg::queue_entry_t                decoded;
  logic                                  accept;
  logic                                  take;

  // classify: single pop is a block of one; zero-length block is refused; longer ones saturate to 64
  always_comb begin
    decoded.data_byte = data_byte;
    decoded.len       = block_length;
    unique case (command)
      mbrf_pkg::CMD_PUSH:  decoded.op = mbrf_pkg::OP_PUSH;
      mbrf_pkg::CMD_FORCE: decoded.op = mbrf_pkg::OP_FORCE;
      mbrf_pkg::CMD_POP: begin
        decoded.op  = mbrf_pkg::OP_POP;
        decoded.len = mbrf_pkg::LEN_W'(1);
      end
      default: begin
        if (block_length == '0) begin
          decoded.op = mbrf_pkg::OP_REFUSE;
        end else begin
          decoded.op = mbrf_pkg::OP_POP;
          if (block_length > mbrf_pkg::LEN_W'(mbrf_pkg::MAX_BLOCK)) begin
            decoded.len = mbrf_pkg::LEN_W'(mbrf_pkg::MAX_BLOCK);
          end
        end
      end
    endcase
  end

  assign busy    = (cnt == mbrf_pkg::QCNT_W'(mbrf_pkg::QUEUE_DEPTH));
  assign accept  = start && !busy;
  assign q_valid = (cnt != '0);
  assign q_entry = slots[rd_ptr];
  assign take    = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + mbrf_pkg::QPTR_W'(1);
      end
      if (take) begin
        rd_ptr <= rd_ptr + mbrf_pkg::QPTR_W'(1);
      end
      if (accept && !take) begin
        cnt <= cnt + mbrf_pkg::QCNT_W'(1);
      end else if (take && !accept) begin
        cnt <= cnt - mbrf_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/mbrf_back.sv =====
// Back end: ring indices with mirror bits, byte store and result register.
// Depends on mbrf_pkg.
`default_nettype none

module mbrf_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_clear,
  input  wire logic [mbrf_pkg::CAP_W-1:0]   cap_use,
  input  wire logic                         q_valid,
  input  wire mbrf_pkg::queue_entry_t       q_entry,
  output logic                              q_take,
  output logic                              result_strobe,
  output logic                              accepted,
  output logic [7:0]                        read_byte,
  output logic                              last,
  output logic [mbrf_pkg::CAP_W-1:0]        fill_level,
  output logic [1:0]                        fifo_status
);

  logic [7:0]                       mem [mbrf_pkg::STORE_DEPTH];
  logic [7:0]                       mem_q;

  mbrf_pkg::ptr_t                   rptr, rptr_next;
  mbrf_pkg::ptr_t                   wptr, wptr_next;
  logic [mbrf_pkg::CAP_W-1:0]       count, count_next;
  logic [mbrf_pkg::LEN_W-1:0]       remaining, remaining_next;
  logic [mbrf_pkg::LEN_W-1:0]       n_pop;

  logic                             full, empty;
  logic                             mem_we, mem_re;
  logic                             emit, e_acc, e_last, e_pop;
  logic                             res_pop;

  assign full  = (rptr.pos == wptr.pos) && (rptr.wrap != wptr.wrap);
  assign empty = (rptr.pos == wptr.pos) && (rptr.wrap == wptr.wrap);
  // count never exceeds len here when it is the smaller one
  assign n_pop = (mbrf_pkg::CAP_W'(q_entry.len) < count) ? q_entry.len
                                                           : mbrf_pkg::LEN_W'(count);

  always_comb begin
    rptr_next      = rptr;
    wptr_next      = wptr;
    count_next     = count;
    remaining_next = remaining;
    q_take         = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    emit           = 1'b0;
    e_acc          = 1'b0;
    e_last         = 1'b1;
    e_pop          = 1'b0;
    if (remaining != '0) begin
      // rest of a block pop, one byte per cycle
      mem_re         = 1'b1;
      rptr_next      = mbrf_pkg::advance(rptr, cap_use);
      count_next     = count - mbrf_pkg::CAP_W'(1);
      remaining_next = remaining - mbrf_pkg::LEN_W'(1);
      emit           = 1'b1;
      e_acc          = 1'b1;
      e_pop          = 1'b1;
      e_last         = (remaining == mbrf_pkg::LEN_W'(1));
    end else if (q_valid) begin
      q_take = 1'b1;
      emit   = 1'b1;
      unique case (q_entry.op)
        mbrf_pkg::OP_PUSH: begin
          if (!full) begin
            mem_we     = 1'b1;
            wptr_next  = mbrf_pkg::advance(wptr, cap_use);
            count_next = count + mbrf_pkg::CAP_W'(1);
            e_acc      = 1'b1;
          end
        end
        mbrf_pkg::OP_FORCE: begin
          mem_we    = 1'b1;
          wptr_next = mbrf_pkg::advance(wptr, cap_use);
          e_acc     = 1'b1;
          if (full) begin
            rptr_next = mbrf_pkg::advance(rptr, cap_use);
          end else begin
            count_next = count + mbrf_pkg::CAP_W'(1);
          end
        end
        mbrf_pkg::OP_POP: begin
          if (!empty) begin
            mem_re         = 1'b1;
            rptr_next      = mbrf_pkg::advance(rptr, cap_use);
            count_next     = count - mbrf_pkg::CAP_W'(1);
            remaining_next = n_pop - mbrf_pkg::LEN_W'(1);
            e_acc          = 1'b1;
            e_pop          = 1'b1;
            e_last         = (n_pop == mbrf_pkg::LEN_W'(1));
          end
        end
        mbrf_pkg::OP_REFUSE: begin
        end
      endcase
    end
  end

  // byte store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wptr.pos] <= q_entry.data_byte;
    end
    if (mem_re) begin
      mem_q <= mem[rptr.pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      rptr          <= '0;
      wptr          <= '0;
      count         <= '0;
      remaining     <= '0;
      result_strobe <= 1'b0;
    end else begin
      rptr          <= rptr_next;
      wptr          <= wptr_next;
      count         <= count_next;
      remaining     <= remaining_next;
      result_strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      accepted    <= e_acc;
      last        <= e_last;
      res_pop     <= e_pop;
      fill_level  <= count_next;
      fifo_status <= mbrf_pkg::status_of(count_next, cap_use);
    end
  end

  assign read_byte = res_pop ? mem_q : 8'd0;

endmodule

`default_nettype wire

// ===== src/mirrored_byte_ring_fifo.sv =====
// Top level of the mirrored byte ring FIFO: config register, front and back.
// Depends on mbrf_pkg, mbrf_front, mbrf_back.
//
//  channel   | handshake                          | payload
//  ----------+------------------------------------+-------------------------------
//  command   | start, busy (beat: start & !busy)  | command, data_byte, block_length
//  result    | result_strobe (one cycle, no stall)| accepted, read_byte, last,
//            |                                    | fill_level, fifo_status
//  config    | APB psel/penable/pwrite, pready=1  | paddr, pwdata, prdata
//
// Each accepted beat lands in a two-entry command queue; the back end takes one
// queued command per cycle while no block pop is streaming out, and a block pop
// holds the back end until its last byte is out.
// Results show up in the cycle after the back end works them (registered store read).
// busy rises only while the command queue is full, i.e. behind a long block pop.
// rst is synchronous: indices, mirror bits, queue and strobe clear; capacity
// returns to 1024. The store itself is not cleared; no unwritten byte is read.
// A capacity write also empties the FIFO.
`default_nettype none

module mirrored_byte_ring_fifo (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // command channel
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   command,
  input  wire logic [7:0]                   data_byte,
  input  wire logic [mbrf_pkg::LEN_W-1:0]   block_length,
  // result channel
  output logic                              result_strobe,
  output logic                              accepted,
  output logic [7:0]                        read_byte,
  output logic                              last,
  output logic [mbrf_pkg::CAP_W-1:0]        fill_level,
  output logic [1:0]                        fifo_status,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [mbrf_pkg::CAP_W-1:0]  capacity;   // raw value as written
  logic [mbrf_pkg::CAP_W-1:0]  cap_use;    // aligned and clamped copy
  logic                        cfg_wr;
  logic                        cap_wr;

  logic                        q_valid;
  logic                        q_take;
  mbrf_pkg::queue_entry_t      q_entry;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  // word index is paddr[2]; byte lanes ignored
  assign cap_wr = cfg_wr && (paddr[2] == mbrf_pkg::REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= mbrf_pkg::CAP_RESET;
      cap_use  <= mbrf_pkg::cap_in_use(mbrf_pkg::CAP_RESET);
    end else if (cap_wr) begin
      capacity <= pwdata[mbrf_pkg::CAP_W-1:0];
      cap_use  <= mbrf_pkg::cap_in_use(pwdata[mbrf_pkg::CAP_W-1:0]);
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == mbrf_pkg::REG_CAPACITY) begin
      prdata = 32'(capacity);
    end
  end

  mbrf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .data_byte    (data_byte),
    .block_length (block_length),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_take       (q_take)
  );

  mbrf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_clear     (cap_wr),
    .cap_use       (cap_use),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .q_take        (q_take),
    .result_strobe (result_strobe),
    .accepted      (accepted),
    .read_byte     (read_byte),
    .last          (last),
    .fill_level    (fill_level),
    .fifo_status   (fifo_status)
  );

endmodule

`default_nettype wire

// ===== src/mbrf_checker.sv =====
// Port-level checks for mirrored_byte_ring_fifo, attached by bind.
// Depends on mbrf_pkg and the top level's ports.
`default_nettype none

module mbrf_port_checks (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         result_strobe,
  input  wire logic                         accepted,
  input  wire logic [7:0]                   read_byte,
  input  wire logic                         last,
  input  wire logic [mbrf_pkg::CAP_W-1:0]   fill_level,
  input  wire logic [1:0]                   fifo_status
);

  // a refused beat is always a single, closing, zero-byte result
  a_refused_shape: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !accepted |-> last && (read_byte == 8'd0))
    else $error("refused result not last or carries a byte");

  // block pop streams: a non-final result is followed by another one
  a_block_stream: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |=> result_strobe && accepted)
    else $error("block pop stream broken");

  // empty status agrees with a zero reported fill level
  a_empty_fill: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> ((fifo_status == mbrf_pkg::STATUS_EMPTY) == (fill_level == '0)))
    else $error("empty status and fill level disagree");

  // consecutive stream bytes drain the fifo by one each
  a_stream_drain: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |=> fill_level == $past(fill_level) - mbrf_pkg::CAP_W'(1))
    else $error("block pop fill level not decreasing by one");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> fill_level <= mbrf_pkg::CAP_TOP)
    else $error("fill level above store depth");

endmodule

bind mirrored_byte_ring_fifo mbrf_port_checks u_mbrf_port_checks (
  .clk           (clk),
  .rst           (rst),
  .result_strobe (result_strobe),
  .accepted      (accepted),
  .read_byte     (read_byte),
  .last          (last),
  .fill_level    (fill_level),
  .fifo_status   (fifo_status)
);

`default_nettype wire

// ===== tb/sv/mbrf_checker.sv =====
// Scoreboard for the mirrored byte ring FIFO: mirrors the store and indices,
// predicts every result beat and compares it against the DUT output.
// Depends on mbrf_pkg.
`default_nettype none

module mbrf_checker
  import mbrf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic [1:0]        command,
  input  wire logic [7:0]        data_byte,
  input  wire logic [LEN_W-1:0]  block_length,
  input  wire logic              result_strobe,
  input  wire logic              accepted,
  input  wire logic [7:0]        read_byte,
  input  wire logic              last,
  input  wire logic [CAP_W-1:0]  fill_level,
  input  wire logic [1:0]        fifo_status,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic              pready,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output int                     error_count,
  output int                     pending
);

  typedef struct {
    logic             accepted;
    logic [7:0]       read_byte;
    logic             last;
    logic [CAP_W-1:0] fill_level;
    logic [1:0]       fifo_status;
  } result_t;

  result_t          expected_results[$];
  logic [7:0]       mirror_store [STORE_DEPTH];
  int               head_idx;
  int               tail_idx;
  bit               head_lap;
  bit               tail_lap;
  logic [CAP_W-1:0] cap_raw;

  function automatic int used_capacity();
    int c;
    c = (int'(cap_raw) / ALIGN_UNIT) * ALIGN_UNIT;
    if (c < ALIGN_UNIT) c = ALIGN_UNIT;
    if (c > (STORE_DEPTH / ALIGN_UNIT) * ALIGN_UNIT) c = (STORE_DEPTH / ALIGN_UNIT) * ALIGN_UNIT;
    return c;
  endfunction

  function automatic int held();
    if (head_idx == tail_idx) return (head_lap == tail_lap) ? 0 : used_capacity();
    if (tail_idx > head_idx) return tail_idx - head_idx;
    return used_capacity() - (head_idx - tail_idx);
  endfunction

  // wrap at the end of the region in use, flipping the lap bit
  task automatic step_index(inout int idx, inout bit lap);
    if (idx + 1 >= used_capacity()) begin
      idx = 0;
      lap = ~lap;
    end else begin
      idx = idx + 1;
    end
  endtask

  task automatic note(input bit acc, input logic [7:0] b, input bit fin);
    result_t r;
    int      f;
    f = held();
    r.accepted   = acc;
    r.read_byte  = b;
    r.last       = fin;
    r.fill_level = CAP_W'(f);
    if (f == 0) begin
      r.fifo_status = STATUS_EMPTY;
    end else if (f == used_capacity()) begin
      r.fifo_status = STATUS_FULL;
    end else begin
      r.fifo_status = STATUS_PARTIAL;
    end
    expected_results.push_back(r);
  endtask

  task automatic predict_results(input logic [1:0] cmd, input logic [7:0] b,
                                 input logic [LEN_W-1:0] len);
    int         n;
    bit         was_full;
    logic [7:0] popped;
    n = 0;
    was_full = (held() == used_capacity());
    if (cmd == CMD_PUSH || cmd == CMD_FORCE) begin
      if (cmd == CMD_PUSH && was_full) begin
        note(1'b0, 8'h00, 1'b1);
      end else begin
        mirror_store[tail_idx] = b;
        step_index(tail_idx, tail_lap);
        // overwrite: oldest byte drops out
        if (was_full) step_index(head_idx, head_lap);
        note(1'b1, 8'h00, 1'b1);
      end
    end else begin
      if (cmd == CMD_POP) begin
        n = (held() > 0) ? 1 : 0;
      end else begin
        n = int'(len);
        if (n > MAX_BLOCK) n = MAX_BLOCK;
        if (n > held()) n = held();
      end
      if (n == 0) begin
        note(1'b0, 8'h00, 1'b1);
      end else begin
        for (int i = 0; i < n; i++) begin
          popped = mirror_store[head_idx];
          step_index(head_idx, head_lap);
          note(1'b1, popped, i == n - 1);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want_r;
    if (rst) begin
      expected_results.delete();
      head_idx    = 0;
      tail_idx    = 0;
      head_lap    = 1'b0;
      tail_lap    = 1'b0;
      cap_raw     = CAP_RESET;
      error_count = 0;
    end else begin
      // result first: it can only belong to a beat accepted earlier
      if (result_strobe) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual accepted=%0d byte=%0d last=%0d fill=%0d status=%0d",
                   $time, accepted, read_byte, last, fill_level, fifo_status);
          error_count++;
        end else begin
          want_r = expected_results.pop_front();
          check_field("accepted", 16'(want_r.accepted), 16'(accepted));
          check_field("read_byte", 16'(want_r.read_byte), 16'(read_byte));
          check_field("last", 16'(want_r.last), 16'(last));
          check_field("fill_level", 16'(want_r.fill_level), 16'(fill_level));
          check_field("fifo_status", 16'(want_r.fifo_status), 16'(fifo_status));
        end
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
        cap_raw  = pwdata[CAP_W-1:0];
        head_idx = 0;
        tail_idx = 0;
        head_lap = 1'b0;
        tail_lap = 1'b0;
      end
      if (start && !busy) predict_results(command, data_byte, block_length);
    end
    pending = expected_results.size();
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_mirrored_byte_ring_fifo.sv =====
// Top of the mirrored byte ring FIFO testbench: clock, reset, command and
// register stimulus, verdict. Depends on mbrf_pkg, mirrored_byte_ring_fifo, mbrf_checker.
`default_nettype none

module tb_mirrored_byte_ring_fifo;
  import mbrf_pkg::*;

  // register map: capacity is index 0; index 1 is unmapped and must be ignored
  localparam logic [2:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED = 3'd4;
  localparam int         RANDOM_BEATS  = 230;

  typedef enum {FILL_UP, DRAIN, MIXED} traffic_t;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             start        = 1'b0;
  logic [1:0]       command      = CMD_PUSH;
  logic [7:0]       data_byte    = 8'h00;
  logic [LEN_W-1:0] block_length = '0;
  logic             psel         = 1'b0;
  logic             penable      = 1'b0;
  logic             pwrite       = 1'b0;
  logic [2:0]       paddr        = 3'd0;
  logic [31:0]      pwdata       = 32'd0;

  logic             busy;
  logic             result_strobe;
  logic             accepted;
  logic [7:0]       read_byte;
  logic             last;
  logic [CAP_W-1:0] fill_level;
  logic [1:0]       fifo_status;
  logic [31:0]      prdata;
  logic             pready;

  int error_count;
  int pending;
  int burst_left = 4;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mirrored_byte_ring_fifo u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .data_byte    (data_byte),
    .block_length (block_length),
    .result_strobe(result_strobe),
    .accepted     (accepted),
    .read_byte    (read_byte),
    .last         (last),
    .fill_level   (fill_level),
    .fifo_status  (fifo_status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // scoreboard sits beside the DUT on the same wires
  mbrf_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .data_byte    (data_byte),
    .block_length (block_length),
    .result_strobe(result_strobe),
    .accepted     (accepted),
    .read_byte    (read_byte),
    .last         (last),
    .fill_level   (fill_level),
    .fifo_status  (fifo_status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .error_count  (error_count),
    .pending      (pending)
  );

  // Mostly short blocks; now and then zero (refused) or above the 64-byte
  // ceiling (saturated), which also toggles the top bit of the field.
  function automatic logic [LEN_W-1:0] draw_block_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return LEN_W'($urandom_range(MAX_BLOCK + 1, 127));
    if (r <= 3) return LEN_W'($urandom_range(13, MAX_BLOCK));
    return LEN_W'($urandom_range(1, 12));
  endfunction

  // One command beat. Called just after a rising edge; holds start high until
  // the edge where busy is low. start stays up across a burst, so back-to-back
  // beats never see a low/high pair in one step. Bursts end in a random gap, which may be empty.
  task automatic issue(input logic [1:0] cmd, input logic [7:0] b,
                       input logic [LEN_W-1:0] len);
    int gap;
    start        <= 1'b1;
    command      <= cmd;
    data_byte    <= b;
    block_length <= len;
    do @(posedge clk); while (busy);
    burst_left--;
    if (burst_left <= 0) begin
      // occasional long stretch with no idle cycles at all
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drain: drop start, wait at the falling edge (no race with the scoreboard)
  // until every predicted beat has come back, then a few spare cycles.
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, done at the edge with pready high.
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    int          random_done;
    int          phase_len;
    int          pick;
    traffic_t    mode;
    logic [1:0]  cmd;
    logic [31:0] cap_word;

    random_done = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // empty FIFO at reset capacity: every kind of pop is refused
    issue(CMD_POP,   8'h00, 7'd1);
    issue(CMD_BLOCK, 8'h00, 7'd5);
    issue(CMD_BLOCK, 8'h00, 7'd0);
    // write to an unmapped index must not touch capacity or empty the FIFO
    issue(CMD_PUSH,  8'hC3, 7'd1);
    settle();
    reg_write(ADDR_UNMAPPED, 32'h0000_0008);
    issue(CMD_POP,   8'h00, 7'd1);
    // capacity 0 is raised to the 4-byte minimum
    settle();
    reg_write(ADDR_CAPACITY, 32'd0);
    issue(CMD_PUSH,  8'h00, 7'd1);
    issue(CMD_PUSH,  8'hFF, 7'd1);
    issue(CMD_PUSH,  8'hA5, 7'd1);
    issue(CMD_PUSH,  8'h5A, 7'd1);
    // full: plain push refused, force push overwrites the oldest byte
    issue(CMD_PUSH,  8'h11, 7'd1);
    issue(CMD_FORCE, 8'h22, 7'd1);
    issue(CMD_FORCE, 8'h33, 7'd1);
    // zero length refused even when data is there
    issue(CMD_BLOCK, 8'h00, 7'd0);
    // length 127: saturated to 64, then clamped to the 4 bytes held
    issue(CMD_BLOCK, 8'h00, 7'd127);
    issue(CMD_POP,   8'h00, 7'd1);
    issue(CMD_FORCE, 8'h7E, 7'd1);
    issue(CMD_BLOCK, 8'h00, 7'd1);

    // --- random ---
    // Capacity above the store (2047) clamps to 1024; put in enough bytes
    // for a block pop that hits the 64-byte ceiling.
    settle();
    reg_write(ADDR_CAPACITY, 32'd2047);
    repeat (68) begin
      issue(($urandom_range(0, 3) == 0) ? CMD_FORCE : CMD_PUSH, 8'($urandom), 7'($urandom));
      random_done++;
    end
    issue(CMD_BLOCK, 8'($urandom), LEN_W'($urandom_range(MAX_BLOCK, 127)));
    repeat (3) issue(CMD_BLOCK, 8'($urandom), draw_block_len());
    random_done += 4;

    // Phases: new capacity each time, traffic shifting between filling,
    // draining and mixed so both full and empty states come up often.
    while (random_done < RANDOM_BEATS) begin
      settle();
      case ($urandom_range(0, 9))
        0:       cap_word = 32'd0;
        1:       cap_word = $urandom_range(1, 3);
        2:       cap_word = 32'd4;
        3:       cap_word = 32'd1023;
        4:       cap_word = 32'd1024;
        5:       cap_word = 32'd2047;
        6:       cap_word = $urandom;    // junk above bit 10 must be dropped
        default: cap_word = $urandom_range(5, 48);
      endcase
      reg_write(ADDR_CAPACITY, cap_word);
      mode = traffic_t'($urandom_range(0, 2));
      phase_len = $urandom_range(12, 30);
      repeat (phase_len) begin
        if ($urandom_range(0, 7) == 0) mode = traffic_t'($urandom_range(0, 2));
        pick = $urandom_range(0, 9);
        case (mode)
          FILL_UP: cmd = (pick < 5) ? CMD_PUSH : (pick < 7) ? CMD_FORCE :
                         (pick < 9) ? CMD_POP : CMD_BLOCK;
          DRAIN:   cmd = (pick < 2) ? CMD_PUSH : (pick < 3) ? CMD_FORCE :
                         (pick < 6) ? CMD_POP : CMD_BLOCK;
          default: cmd = (pick < 3) ? CMD_PUSH : (pick < 4) ? CMD_FORCE :
                         (pick < 7) ? CMD_POP : CMD_BLOCK;
        endcase
        issue(cmd, 8'($urandom), draw_block_len());
        random_done++;
      end
    end

    // everything back, then a margin for stray beats
    settle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

// ===== mirrored_byte_ring_fifo.f =====
src/mbrf_pkg.sv
src/mbrf_front.sv
src/mbrf_back.sv
src/mirrored_byte_ring_fifo.sv
src/mbrf_checker.sv
tb/sv/mbrf_checker.sv
tb/sv/tb_mirrored_byte_ring_fifo.sv
